FILE: hdl/sca_pkg.sv
package sca_pkg;
    localparam int SLAB_BYTES  = 4096;
    localparam int NUM_CLASSES = 20;
    localparam int ALIGN_BYTES = 16;
    localparam int NUM_SLABS   = 256;
    localparam int BIG_BYTES   = 1048576;

    localparam int CID_W   = 5;
    localparam int SLAB_W  = 9;
    localparam int ITEM_W  = 9;
    localparam int CSIZE_W = 13;
    localparam int ADDR_W  = 21;
    localparam int BIG_W   = 21;
    localparam int CFG_W   = 12;

    localparam logic [0:0] CFG_MAX_ITEM = 1'b0;
    localparam logic [0:0] CFG_GROWTH   = 1'b1;

    localparam logic [1:0] ST_SLAB = 2'd0;
    localparam logic [1:0] ST_BIG  = 2'd1;
    localparam logic [1:0] ST_NULL = 2'd2;
    localparam logic [1:0] ST_OOM  = 2'd3;

    typedef enum logic [2:0] {
        S_BUILD,
        S_IDLE,
        S_SEARCH,
        S_ALLOC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic build_start;
        logic build_step;
        logic load_req;
        logic search_step;
        logic alloc;
        logic clear_left;
    } cmd_t;

    typedef struct packed {
        logic build_done;
        logic search_done;
    } stat_t;
endpackage

FILE: hdl/sca_if.sv
interface sca_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] req_size;
    modport source (output valid, output req_size, input ready);
    modport sink (input valid, input req_size, output ready);
endinterface

interface sca_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [20:0] address;
    logic [4:0]  class_id;
    modport source (output valid, output status, output address, output class_id,
                    input ready);
    modport sink (input valid, input status, input address, input class_id,
                  output ready);
endinterface

FILE: hdl/slab_class_allocator_unit.sv
// Slab class allocator: one request in, one result out. After reset or any
// register write the size-class table is rebuilt, one class after another
// (a bit-serial divide gives the items per slab), while no request is taken.
// A request then walks the class table one entry a cycle (up to 20 entries),
// takes an allocate step and waits in the output register until taken; only
// then is the next request accepted.
module slab_class_allocator_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [sca_pkg::CFG_W-1:0] cfg_data,
    sca_req_if.sink                   req,
    sca_res_if.source                 res
);
    import sca_pkg::*;

    cmd_t cmd;
    stat_t stat;

    sca_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .in_valid(req.valid),
        .out_ready(res.ready), .stat(stat), .cmd(cmd), .in_ready(req.ready),
        .out_valid(res.valid)
    );

    sca_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_sel(cfg_index),
        .cfg_data(cfg_data), .req_size(req.req_size), .cmd(cmd), .stat(stat),
        .status(res.status), .address(res.address), .class_id(res.class_id)
    );
endmodule

FILE: hdl/sca_ctrl.sv
module sca_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           in_valid,
    input  logic           out_ready,
    input  sca_pkg::stat_t stat,
    output sca_pkg::cmd_t  cmd,
    output logic           in_ready,
    output logic           out_valid
);
    import sca_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_BUILD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_BUILD:  if (stat.build_done) state_next = S_IDLE;
            S_IDLE:
            begin
                if (cfg_we)
                    state_next = S_BUILD;
                else if (in_valid)
                    state_next = S_SEARCH;
            end
            S_SEARCH: if (stat.search_done) state_next = S_ALLOC;
            S_ALLOC:  state_next = S_OUT;
            S_OUT:    if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        // a write restarts the table build from any state
        if (cfg_we)
            state_next = S_BUILD;
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd.build_start = cfg_we;
        cmd.clear_left  = cfg_we;
        unique case (state_reg)
            S_BUILD:  cmd.build_step = !cfg_we;
            S_IDLE:
            begin
                in_ready     = !cfg_we;
                cmd.load_req = in_valid && !cfg_we;
            end
            S_SEARCH: cmd.search_step = 1'b1;
            S_ALLOC:  cmd.alloc = 1'b1;
            S_OUT:    out_valid = 1'b1;
            default:  ;
        endcase
    end
endmodule

FILE: hdl/sca_dp.sv
module sca_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [0:0]                cfg_sel,
    input  logic [sca_pkg::CFG_W-1:0] cfg_data,
    input  logic [15:0]               req_size,
    input  sca_pkg::cmd_t             cmd,
    output sca_pkg::stat_t            stat,
    output logic [1:0]                status,
    output logic [20:0]               address,
    output logic [4:0]                class_id
);
    import sca_pkg::*;

    logic [11:0] max_reg;
    logic [10:0] gf_reg;

    logic [CSIZE_W-1:0] csize_reg [NUM_CLASSES];
    logic [ITEM_W-1:0]  cper_reg  [NUM_CLASSES];
    logic [CID_W-1:0]   ccount_reg;

    logic [SLAB_W-1:0]  cslab_reg [NUM_CLASSES];
    logic [7:0]         cnext_reg [NUM_CLASSES];
    logic [ITEM_W-1:0]  cleft_reg [NUM_CLASSES];
    logic [SLAB_W-1:0]  free_slab_reg;
    logic [BIG_W-1:0]   big_off_reg;

    // table build: one class per pass; per-slab count by restoring division
    logic [23:0] run_reg;
    logic [CSIZE_W-1:0] s_reg;
    logic [CID_W-1:0] bn_reg;
    logic [1:0] bph_reg;
    logic [3:0] dcnt_reg;
    logic [12:0] rem_reg;
    logic [ITEM_W-1:0] quo_reg;
    logic build_done_reg;

    logic [15:0] size_reg;
    logic [CID_W-1:0] sid_reg;
    logic found_reg, sdone_reg;

    logic [1:0] st_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CID_W-1:0] cid_reg;

    logic [24:0] run_round;
    logic [CSIZE_W-1:0] s_val;
    logic [13:0] rem_sh;
    logic [16:0] need;
    logic [21:0] big_sum;

    always_comb
    begin
        run_round = {1'b0, run_reg} + 25'(ALIGN_BYTES - 1);
        s_val = CSIZE_W'(run_round >> 4 << 4);
        // a zero running size still gives the smallest class
        if (s_val < CSIZE_W'(ALIGN_BYTES))
            s_val = CSIZE_W'(ALIGN_BYTES);
        rem_sh = {rem_reg, 1'b0} | 14'((13'(SLAB_BYTES) >> dcnt_reg) & 13'd1);
        need = ({1'b0, size_reg} + 17'(ALIGN_BYTES - 1)) & ~17'(ALIGN_BYTES - 1);
        big_sum = {1'b0, big_off_reg} + 22'(need);
    end

    assign stat.build_done  = build_done_reg;
    assign stat.search_done = sdone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= 12'd1024;
            gf_reg <= 11'd320;
            ccount_reg <= '0;
            free_slab_reg <= '0;
            big_off_reg <= '0;
            run_reg <= 24'(ALIGN_BYTES);
            bn_reg <= '0;
            bph_reg <= '0;
            build_done_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                cleft_reg[i] <= '0;
                cslab_reg[i] <= '0;
                cnext_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.build_start)
            begin
                if (cfg_sel == CFG_MAX_ITEM)
                    max_reg <= cfg_data;
                else
                    gf_reg <= cfg_data[10:0];
                run_reg <= 24'(ALIGN_BYTES);
                bn_reg <= '0;
                bph_reg <= '0;
                build_done_reg <= 1'b0;
            end
            else if (cmd.build_step && !build_done_reg)
            begin
                unique case (bph_reg)
                    2'd0:
                    begin
                        if (bn_reg == CID_W'(NUM_CLASSES) || run_reg > 24'(max_reg)
                            || s_val > CSIZE_W'(SLAB_BYTES))
                        begin
                            ccount_reg <= bn_reg;
                            build_done_reg <= 1'b1;
                        end
                        else
                        begin
                            s_reg <= s_val;
                            rem_reg <= '0;
                            quo_reg <= '0;
                            dcnt_reg <= 4'd12;
                            bph_reg <= 2'd1;
                        end
                    end
                    2'd1:
                    begin
                        // SLAB_BYTES / s, one quotient bit per cycle
                        if (rem_sh >= 14'(s_reg))
                        begin
                            rem_reg <= 13'(rem_sh - 14'(s_reg));
                            quo_reg <= {quo_reg[ITEM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh[12:0];
                            quo_reg <= {quo_reg[ITEM_W-2:0], 1'b0};
                        end
                        if (dcnt_reg == 4'd0)
                            bph_reg <= 2'd2;
                        else
                            dcnt_reg <= dcnt_reg - 4'd1;
                    end
                    default:
                    begin
                        csize_reg[bn_reg] <= s_reg;
                        cper_reg[bn_reg] <= quo_reg;
                        bn_reg <= bn_reg + 5'd1;
                        run_reg <= 24'((24'(s_reg) * 24'(gf_reg)) >> 8);
                        bph_reg <= 2'd0;
                    end
                endcase
            end
            if (cmd.clear_left)
                for (int i = 0; i < NUM_CLASSES; i++)
                    cleft_reg[i] <= '0;
            if (cmd.alloc && size_reg != 16'd0)
            begin
                if (found_reg)
                begin
                    if (cleft_reg[sid_reg] == '0)
                    begin
                        if (free_slab_reg < SLAB_W'(NUM_SLABS))
                        begin
                            cslab_reg[sid_reg] <= free_slab_reg;
                            free_slab_reg <= free_slab_reg + 9'd1;
                            cnext_reg[sid_reg] <= 8'd1;
                            cleft_reg[sid_reg] <= cper_reg[sid_reg] - 9'd1;
                        end
                    end
                    else
                    begin
                        cnext_reg[sid_reg] <= cnext_reg[sid_reg] + 8'd1;
                        cleft_reg[sid_reg] <= cleft_reg[sid_reg] - 9'd1;
                    end
                end
                else if (big_sum <= 22'(BIG_BYTES))
                    big_off_reg <= big_sum[BIG_W-1:0];
            end
        end
    end

    // class search: one class compare per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            size_reg <= req_size;
            sid_reg <= '0;
            found_reg <= 1'b0;
            sdone_reg <= (req_size == 16'd0) || (req_size > 16'(max_reg))
                         || (ccount_reg == '0);
        end
        else if (cmd.search_step && !sdone_reg)
        begin
            if (16'(csize_reg[sid_reg]) >= size_reg)
            begin
                found_reg <= 1'b1;
                sdone_reg <= 1'b1;
            end
            else if (sid_reg + 5'd1 >= ccount_reg)
                sdone_reg <= 1'b1;
            else
                sid_reg <= sid_reg + 5'd1;
        end
    end

    logic [SLAB_W-1:0] use_slab;
    logic [7:0] use_item;
    logic [20:0] item_off;
    always_comb
    begin
        use_slab = (cleft_reg[sid_reg] == '0) ? free_slab_reg : cslab_reg[sid_reg];
        use_item = (cleft_reg[sid_reg] == '0) ? 8'd0 : cnext_reg[sid_reg];
        item_off = 21'(use_item * csize_reg[sid_reg]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            st_reg <= ST_OOM;
            addr_reg <= '0;
            cid_reg <= '0;
            if (size_reg == 16'd0)
                st_reg <= ST_NULL;
            else if (found_reg)
            begin
                if (cleft_reg[sid_reg] != '0 || free_slab_reg < SLAB_W'(NUM_SLABS))
                begin
                    st_reg <= ST_SLAB;
                    addr_reg <= 21'({use_slab, 12'd0}) + item_off;
                    cid_reg <= sid_reg;
                end
            end
            else if (big_sum <= 22'(BIG_BYTES))
            begin
                st_reg <= ST_BIG;
                addr_reg <= 21'(NUM_SLABS * SLAB_BYTES) + big_off_reg;
            end
        end
    end

    assign status   = st_reg;
    assign address  = addr_reg;
    assign class_id = cid_reg;
endmodule

FILE: sim/slab_class_allocator_unit_tb.sv
module slab_class_allocator_unit_tb;
    import sca_pkg::*;

    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES  = 8;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [1:0]        status;
        logic [ADDR_W-1:0] address;
        logic [CID_W-1:0]  class_id;
    } alloc_word_t;

    typedef struct {
        logic [15:0]       size;
        bit                typed;
        logic [1:0]        status;
        logic [ADDR_W-1:0] address;
        logic [CID_W-1:0]  class_id;
    } req_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = CFG_MAX_ITEM;
    logic [CFG_W-1:0] cfg_data = '0;

    sca_req_if req_ch ();
    sca_res_if res_ch ();

    slab_class_allocator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // allocator image
    int unsigned max_item;
    int unsigned growth;
    int unsigned class_bytes [NUM_CLASSES];
    int unsigned class_per_slab [NUM_CLASSES];
    int unsigned class_count;
    int unsigned owned_slab [NUM_CLASSES];
    int unsigned next_item [NUM_CLASSES];
    int unsigned items_left [NUM_CLASSES];
    int unsigned slab_cursor;
    int unsigned big_cursor;

    alloc_word_t pending_allocs [$];
    int errors = 0;
    int status_seen [4];
    bit quiet = 1'b0;

    function automatic longint unsigned align_up(longint unsigned d);
        return ((d + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic void rebuild_classes();
        longint unsigned run;
        longint unsigned s;
        run = ALIGN_BYTES;
        class_count = 0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            class_bytes[i] = 0;
            class_per_slab[i] = 0;
            items_left[i] = 0;
        end
        while (class_count < NUM_CLASSES && run <= max_item)
        begin
            s = align_up(run);
            if (s < ALIGN_BYTES)
                s = ALIGN_BYTES;
            if (s > SLAB_BYTES)
                break;
            class_bytes[class_count] = 32'(s);
            class_per_slab[class_count] = 32'(SLAB_BYTES / s);
            class_count++;
            run = (s * growth) >> 8;
        end
    endfunction

    function automatic alloc_word_t allocate(logic [15:0] size);
        alloc_word_t w;
        int unsigned id;
        bit found;
        longint unsigned need;
        w.status = ST_OOM;
        w.address = '0;
        w.class_id = '0;
        found = 1'b0;
        id = 0;
        if (size == 0)
            w.status = ST_NULL;
        else
        begin
            if (size <= max_item)
                for (id = 0; id < class_count; id++)
                    if (class_bytes[id] >= size)
                    begin
                        found = 1'b1;
                        break;
                    end
            if (found)
            begin
                if (items_left[id] == 0 && slab_cursor < NUM_SLABS)
                begin
                    owned_slab[id] = slab_cursor;
                    slab_cursor++;
                    next_item[id] = 0;
                    items_left[id] = class_per_slab[id];
                end
                if (items_left[id] != 0)
                begin
                    w.address = ADDR_W'(owned_slab[id] * SLAB_BYTES
                                        + next_item[id] * class_bytes[id]);
                    next_item[id]++;
                    items_left[id]--;
                    w.status = ST_SLAB;
                    w.class_id = CID_W'(id);
                end
            end
            else
            begin
                need = align_up(size);
                if (big_cursor + need <= BIG_BYTES)
                begin
                    w.address = ADDR_W'(NUM_SLABS * SLAB_BYTES + big_cursor);
                    big_cursor += 32'(need);
                    w.status = ST_BIG;
                end
            end
        end
        return w;
    endfunction

    // request side
    task automatic idle_burst();
        if (!quiet && $urandom_range(3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_request(logic [15:0] size, bit typed, alloc_word_t typed_word);
        alloc_word_t w;
        idle_burst();
        req_ch.valid <= 1'b1;
        req_ch.req_size <= size;
        do @(posedge clk); while (!req_ch.ready);
        w = allocate(size);
        pending_allocs.push_back(typed ? typed_word : w);
    endtask

    task automatic write_reg(logic [0:0] idx, int unsigned value);
        req_ch.valid <= 1'b0;
        wait (pending_allocs.size() == 0);
        repeat (30) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_ITEM)
            max_item = value & 12'hFFF;
        else
            growth = value & 11'h7FF;
        rebuild_classes();
    endtask

    function automatic logic [15:0] pick_size();
        int unsigned r;
        int unsigned top;
        r = $urandom_range(99);
        top = (max_item > SLAB_BYTES) ? SLAB_BYTES : max_item;
        if (r < 5)
            return 16'd0;
        else if (r < 65 && top >= 1)
            return 16'($urandom_range(1, top + 1));
        else if (r < 80)
            return 16'($urandom_range(1, 64));
        return 16'($urandom());
    endfunction

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (!quiet && $urandom_range(4) == 0)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        alloc_word_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_allocs.size() == 0)
            begin
                $error("unexpected word: status %0d address %0h", res_ch.status,
                       res_ch.address);
                errors++;
            end
            else
            begin
                e = pending_allocs.pop_front();
                status_seen[res_ch.status]++;
                if (res_ch.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, res_ch.status);
                    errors++;
                end
                if (res_ch.address !== e.address)
                begin
                    $error("address: expected %0h, got %0h", e.address, res_ch.address);
                    errors++;
                end
                if (res_ch.class_id !== e.class_id)
                begin
                    $error("class_id: expected %0d, got %0d", e.class_id, res_ch.class_id);
                    errors++;
                end
            end
        end
    end

    // hang detector: cycles without any word moving
    int stall_cycles = 0;
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("slab_class_allocator_unit_tb: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    req_row_t directed [] = '{
        '{16'd0,     1'b1, ST_NULL, 21'd0,       5'd0},
        '{16'd1,     1'b1, ST_SLAB, 21'd0,       5'd0},
        '{16'd16,    1'b1, ST_SLAB, 21'd16,      5'd0},
        '{16'd17,    1'b1, ST_SLAB, 21'd4096,    5'd1},
        '{16'd1024,  1'b1, ST_BIG,  21'd1048576, 5'd0},
        '{16'd1025,  1'b1, ST_BIG,  21'd1049600, 5'd0},
        '{16'd65535, 1'b0, ST_OOM,  21'd0,       5'd0},
        '{16'd960,   1'b0, ST_OOM,  21'd0,       5'd0},
        '{16'd961,   1'b0, ST_OOM,  21'd0,       5'd0},
        '{16'd2,     1'b0, ST_OOM,  21'd0,       5'd0},
        '{16'd15,    1'b0, ST_OOM,  21'd0,       5'd0},
        '{16'd33,    1'b0, ST_OOM,  21'd0,       5'd0},
        '{16'd500,   1'b0, ST_OOM,  21'd0,       5'd0},
        '{16'd4096,  1'b0, ST_OOM,  21'd0,       5'd0},
        '{16'd32768, 1'b0, ST_OOM,  21'd0,       5'd0},
        '{16'hAAAA,  1'b0, ST_OOM,  21'd0,       5'd0},
        '{16'h5555,  1'b0, ST_OOM,  21'd0,       5'd0}
    };

    // register settings per phase: size limit, growth factor
    int unsigned phase_max [NUM_PHASES] = '{4095, 16, 15, 4095, 2000, 300, 0, 1024};
    int unsigned phase_grow [NUM_PHASES] = '{1024, 257, 320, 257, 2047, 0, 512, 320};

    initial
    begin
        alloc_word_t tw;
        req_ch.valid = 1'b0;
        req_ch.req_size = '0;
        max_item = 1024;
        growth = 320;
        slab_cursor = 0;
        big_cursor = 0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            owned_slab[i] = 0;
            next_item[i] = 0;
        end
        rebuild_classes();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            tw.status = directed[i].status;
            tw.address = directed[i].address;
            tw.class_id = directed[i].class_id;
            send_request(directed[i].size, directed[i].typed, tw);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(CFG_MAX_ITEM, phase_max[p]);
            write_reg(CFG_GROWTH, phase_grow[p]);
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(pick_size(), 1'b0, tw);
        end
        req_ch.valid <= 1'b0;

        wait (pending_allocs.size() == 0);
        repeat (30) @(posedge clk);
        $display("ran %0d register settings; words: %0d slab, %0d big, %0d null, %0d oom",
                 NUM_PHASES + 1, status_seen[ST_SLAB], status_seen[ST_BIG],
                 status_seen[ST_NULL], status_seen[ST_OOM]);
        $display("slabs handed out %0d of %0d, big region used %0d bytes",
                 slab_cursor, NUM_SLABS, big_cursor);
        if (errors == 0)
            $display("slab_class_allocator_unit_tb: done, clean");
        else
            $display("slab_class_allocator_unit_tb: done, errors");
        $finish;
    end
endmodule
